/* hw/rtl/water_ripple_height_field_assert.svh */
// Assertion shorthands for the ripple height field checks.
// Each expects i_clk and i_rst_n in the scope of use.
`ifndef WATER_RIPPLE_HEIGHT_FIELD_ASSERT_SVH
`define WATER_RIPPLE_HEIGHT_FIELD_ASSERT_SVH

// same-cycle implication
`define WRHF_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wrhf check failed");

// next-cycle implication
`define WRHF_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wrhf check failed");

`endif

/* hw/rtl/wrhf_pkg.sv */
`timescale 1ns / 1ps

package wrhf_pkg;

    localparam int COORD_W  = 7;
    localparam int AMOUNT_W = 10;
    localparam int HEIGHT_W = 16;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] REQ_ADVANCE = 2'd0;
    localparam logic [KIND_W-1:0] REQ_READ    = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CLEAR   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   req_type;
        logic                spawn_enable;
        logic [COORD_W-1:0]  spawn_x;
        logic [COORD_W-1:0]  spawn_y;
        logic [AMOUNT_W-1:0] spawn_amount;
        logic [COORD_W-1:0]  read_x;
        logic [COORD_W-1:0]  read_y;
    } t_req_beat;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [KIND_W-1:0]          done_kind;
    } t_rsp_beat;

endpackage

/* hw/rtl/wrhf_chan_if.sv */
`timescale 1ns / 1ps

interface wrhf_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/water_ripple_height_field.sv */
// Channel   Dir  Beat         Content
// i_req     in   t_req_beat   advance / read / clear request
// o_rsp     out  t_rsp_beat   height (reads only) and echoed request kind
//
// Advance: each cell needs four neighbours from the older grid, whose memory has two
// read ports. Clear: one entry of both grids per cycle.
// After reset both grids are swept to zero; ready stays low.
// A finished result waits in its last state while the output register is full;
// a new request is taken while the previous result is still held there.
`timescale 1ns / 1ps

module water_ripple_height_field
    import wrhf_pkg::*;
#(
    parameter int GRID_BITS = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wrhf_chan_if.sink    i_req,
    wrhf_chan_if.source  o_rsp
);

    localparam int CELL_BITS = 2 * GRID_BITS;
    localparam int CELLS     = 1 << CELL_BITS;
    localparam logic [CELL_BITS-1:0] ROW_STEP = CELL_BITS'(1 << GRID_BITS);
    localparam logic [CELL_BITS-1:0] ONE      = CELL_BITS'(1);
    localparam logic [2:0] SPL_LAST = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SPL_RD, S_SPL_WR, S_SWEEP, S_DRAIN, S_FIN
    } t_state;

    logic [HEIGHT_W-1:0] r_grid_first  [CELLS];
    logic [HEIGHT_W-1:0] r_grid_second [CELLS];
    logic [HEIGHT_W-1:0] r_q0a, r_q0b, r_q1a, r_q1b;

    t_state               r_state;
    logic                 r_sel;
    logic [CELL_BITS-1:0] r_cnt;
    logic                 r_ph;
    logic                 r_p1, r_p2, r_p3;
    logic                 r_clr_req;
    logic [2:0]           r_sp;
    logic [GRID_BITS-1:0] r_spx, r_spy;
    logic [AMOUNT_W-1:0]  r_amt;
    logic [KIND_W-1:0]    r_kind;
    logic [HEIGHT_W-1:0]  r_res_height;
    logic                 r_out_valid;
    t_rsp_beat            r_out_data;

    logic [CELL_BITS-1:0] r_ia, r_iw;
    logic [16:0]          r_sum_ud;
    logic [HEIGHT_W-1:0]  r_old;
    logic [HEIGHT_W-1:0]  r_v;

    logic [CELL_BITS-1:0] old_ra, old_rb, cur_ra, spl_addr;
    logic [HEIGHT_W-1:0]  old_qa, old_qb, cur_qa, spl_add;
    logic                 old_we, cur_we, clr_we;
    logic [CELL_BITS-1:0] old_wa, cur_wa;
    logic [HEIGHT_W-1:0]  old_wd, cur_wd;
    logic                 m0_we, m1_we;
    logic [CELL_BITS-1:0] m0_wa, m1_wa, m0_ra, m1_ra;
    logic [HEIGHT_W-1:0]  m0_wd, m1_wd;
    logic                 out_load;

    logic [16:0]          n_sum_ud, lr_sum;
    logic [17:0]          sum4;
    logic [HEIGHT_W-1:0]  n_v;

    // old grid is the source of the sweep, current grid the destination
    assign old_qa = r_sel ? r_q0a : r_q1a;
    assign old_qb = r_sel ? r_q0b : r_q1b;
    assign cur_qa = r_sel ? r_q1a : r_q0a;

    always_comb begin
        unique case (r_sp)
            3'd1:    spl_addr = {r_spy, r_spx + GRID_BITS'(1)};
            3'd2:    spl_addr = {r_spy, r_spx - GRID_BITS'(1)};
            3'd3:    spl_addr = {r_spy + GRID_BITS'(1), r_spx};
            3'd4:    spl_addr = {r_spy - GRID_BITS'(1), r_spx};
            default: spl_addr = {r_spy, r_spx};
        endcase
        spl_add = (r_sp == 3'd0) ? HEIGHT_W'(r_amt) : HEIGHT_W'(r_amt >> 2);
    end

    always_comb begin
        old_ra = r_ph ? r_cnt - ONE : r_cnt - ROW_STEP;
        old_rb = r_ph ? r_cnt + ONE : r_cnt + ROW_STEP;
        cur_ra = r_cnt;
        if (r_state == S_SPL_RD || r_state == S_SPL_WR) begin
            old_ra = spl_addr;
        end
        if (r_state == S_IDLE) begin
            cur_ra = {GRID_BITS'(i_req.data.read_y), GRID_BITS'(i_req.data.read_x)};
        end
    end

    // wave arithmetic: sums stay wide, each new height wraps to 16 bits
    always_comb begin
        n_sum_ud = {old_qa[HEIGHT_W-1], old_qa} + {old_qb[HEIGHT_W-1], old_qb};
        lr_sum   = {old_qa[HEIGHT_W-1], old_qa} + {old_qb[HEIGHT_W-1], old_qb};
        sum4     = {r_sum_ud[16], r_sum_ud} + {lr_sum[16], lr_sum};
        n_v      = sum4[16:1] - r_old;
        cur_wd   = r_v - {{6{r_v[HEIGHT_W-1]}}, r_v[HEIGHT_W-1:6]};
    end

    assign old_we = (r_state == S_SPL_WR);
    assign old_wa = spl_addr;
    assign old_wd = old_qa + spl_add;
    assign cur_we = r_p3;
    assign cur_wa = r_iw;
    assign clr_we = (r_state == S_CLEAR);

    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        m0_we = clr_we || (r_sel ? old_we : cur_we);
        m1_we = clr_we || (r_sel ? cur_we : old_we);
        m0_wa = clr_we ? r_cnt : (r_sel ? old_wa : cur_wa);
        m1_wa = clr_we ? r_cnt : (r_sel ? cur_wa : old_wa);
        m0_wd = clr_we ? '0 : (r_sel ? old_wd : cur_wd);
        m1_wd = clr_we ? '0 : (r_sel ? cur_wd : old_wd);
        m0_ra = r_sel ? old_ra : cur_ra;
        m1_ra = r_sel ? cur_ra : old_ra;
    end

    always_ff @(posedge i_clk) begin
        if (m0_we) begin
            r_grid_first[m0_wa] <= m0_wd;
        end
        r_q0a <= r_grid_first[m0_ra];
        r_q0b <= r_grid_first[old_rb];
    end

    always_ff @(posedge i_clk) begin
        if (m1_we) begin
            r_grid_second[m1_wa] <= m1_wd;
        end
        r_q1a <= r_grid_second[m1_ra];
        r_q1b <= r_grid_second[old_rb];
    end

    // sweep pipeline: up/down pair and old value, then full sum, then damp and write
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP && !r_ph) begin
            r_ia <= r_cnt;
        end
        if (r_p1) begin
            r_sum_ud <= n_sum_ud;
            r_old    <= cur_qa;
        end
        if (r_p2) begin
            r_v  <= n_v;
            r_iw <= r_ia;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
            r_ph        <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_p3        <= 1'b0;
            r_clr_req   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_SWEEP) && !r_ph;
            r_p2 <= (r_state == S_SWEEP) && r_ph;
            r_p3 <= r_p2;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + ONE;
                    if (&r_cnt) begin
                        r_clr_req <= 1'b0;
                        r_state   <= r_clr_req ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind       <= i_req.data.req_type;
                        r_res_height <= '0;
                        r_cnt        <= '0;
                        r_ph         <= 1'b0;
                        r_sp         <= '0;
                        r_spx        <= GRID_BITS'(i_req.data.spawn_x);
                        r_spy        <= GRID_BITS'(i_req.data.spawn_y);
                        r_amt        <= i_req.data.spawn_amount;
                        unique case (i_req.data.req_type)
                            REQ_ADVANCE: begin
                                r_sel   <= ~r_sel;
                                r_state <= i_req.data.spawn_enable ? S_SPL_RD : S_SWEEP;
                            end
                            REQ_READ: r_state <= S_READ;
                            REQ_CLEAR: begin
                                r_sel     <= 1'b0;
                                r_clr_req <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_READ: begin
                    r_res_height <= cur_qa;
                    r_state      <= S_FIN;
                end
                S_SPL_RD: r_state <= S_SPL_WR;
                S_SPL_WR: begin
                    if (r_sp == SPL_LAST) begin
                        r_state <= S_SWEEP;
                    end else begin
                        r_sp    <= r_sp + 3'd1;
                        r_state <= S_SPL_RD;
                    end
                end
                S_SWEEP: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (&r_cnt) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_cnt <= r_cnt + ONE;
                        end
                    end
                end
                S_DRAIN: begin
                    // wait for the last cell's write
                    if (!r_p2 && !r_p3) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_data.height    <= r_res_height;
                        r_out_data.done_kind <= r_kind;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule

/* hw/rtl/wrhf_checker.sv */
`timescale 1ns / 1ps

module wrhf_checker
    import wrhf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [HEIGHT_W-1:0] i_rsp_height,
    input logic [KIND_W-1:0]   i_rsp_kind
);

`include "water_ripple_height_field_assert.svh"

    logic [1:0] r_pend;
    logic       req_acc, rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    `WRHF_NEXT(a_one_at_a_time, req_acc, !i_req_ready)
    `WRHF_IMPLIES(a_pend_bound, req_acc, r_pend != 2'd2)
    `WRHF_IMPLIES(a_no_stray_rsp, i_rsp_valid, r_pend != 2'd0)
    `WRHF_IMPLIES(a_zero_height, i_rsp_valid && i_rsp_kind != REQ_READ, i_rsp_height == '0)
    `WRHF_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

endmodule

bind water_ripple_height_field wrhf_checker u_wrhf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_height (o_rsp.data.height),
    .i_rsp_kind   (o_rsp.data.done_kind)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import wrhf_pkg::*;

    localparam int GRID_BITS   = 7;
    localparam int GRID_W      = 1 << GRID_BITS;
    localparam int CELLS       = GRID_W * GRID_W;
    localparam int CELL_MASK   = CELLS - 1;
    localparam int HALF_PERIOD = 6;
    localparam int QUIET_LIMIT = 150000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;
    localparam int N_RANDOM    = 70;
    localparam int REQ_BITS    = $bits(t_req_beat);

    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wrhf_chan_if #(.T(t_req_beat)) req_if ();
    wrhf_chan_if #(.T(t_rsp_beat)) rsp_if ();

    water_ripple_height_field #(
        .GRID_BITS(GRID_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    class height_field_model;
        bit [HEIGHT_W-1:0] grid [2][CELLS];
        bit                newest;
        t_rsp_beat         pending [$];
        int                errors;

        function new();
            clear_grids();
        endfunction

        function void clear_grids();
            foreach (grid[g, c]) grid[g][c] = '0;
            newest = 1'b0;
        endfunction

        function int cell_of(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            return int'(x) + (int'(y) << GRID_BITS);
        endfunction

        function void add_at(bit g, int idx, bit [HEIGHT_W-1:0] amt);
            grid[g][idx] = grid[g][idx] + amt;
        endfunction

        // centre gets the full amount, the four 2D-wrapped neighbours a quarter
        function void splash(bit g, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [AMOUNT_W-1:0] amount);
            logic [COORD_W-1:0] xp, xm, yp, ym;
            bit [HEIGHT_W-1:0]  quarter;
            xp = x + 1'b1;
            xm = x - 1'b1;
            yp = y + 1'b1;
            ym = y - 1'b1;
            quarter = HEIGHT_W'(amount >> 2);
            add_at(g, cell_of(x, y), HEIGHT_W'(amount));
            add_at(g, cell_of(xp, y), quarter);
            add_at(g, cell_of(xm, y), quarter);
            add_at(g, cell_of(x, yp), quarter);
            add_at(g, cell_of(x, ym), quarter);
        endfunction

        // neighbours wrap over the flat cell index, so row ends spill into the next row
        function void propagate(bit src, bit dst);
            int                   sum;
            logic signed [15:0]   v;
            for (int j = 0; j < CELLS; j++) begin
                sum = int'($signed(grid[src][(j - GRID_W) & CELL_MASK]))
                    + int'($signed(grid[src][(j - 1) & CELL_MASK]))
                    + int'($signed(grid[src][(j + 1) & CELL_MASK]))
                    + int'($signed(grid[src][(j + GRID_W) & CELL_MASK]));
                v = 16'((sum >>> 1) - int'($signed(grid[dst][j])));
                v = v - (v >>> 6);
                grid[dst][j] = v;
            end
        endfunction

        function void note_request(t_req_beat r);
            t_rsp_beat e;
            e.height    = '0;
            e.done_kind = r.req_type;
            case (r.req_type)
                REQ_ADVANCE: begin
                    newest = !newest;
                    if (r.spawn_enable)
                        splash(!newest, r.spawn_x, r.spawn_y, r.spawn_amount);
                    propagate(!newest, newest);
                end
                REQ_READ: begin
                    e.height = grid[newest][cell_of(r.read_x, r.read_y)];
                end
                REQ_CLEAR: begin
                    clear_grids();
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        endtask

        task check_response(t_rsp_beat got);
            t_rsp_beat want;
            if (pending.size() == 0) begin
                report("unrequested beat, done_kind", int'(got.done_kind), -1);
                return;
            end
            want = pending.pop_front();
            if (got.height !== want.height)
                report($sformatf("height (kind %0d)", want.done_kind),
                       int'(got.height), int'(want.height));
            if (got.done_kind !== want.done_kind)
                report("done_kind", int'(got.done_kind), int'(want.done_kind));
        endtask

        task check_drained();
            if (pending.size() != 0)
                report("beats never returned", 0, pending.size());
        endtask
    endclass

    height_field_model ripple = new();

    int quiet_cycles = 0;
    bit hold_off_req = 1'b0;
    bit snd_calm     = 1'b0;
    bit rcv_calm     = 1'b0;

    // switch between stretches of random gaps and stretches with none
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic t_req_beat mk_req(logic [KIND_W-1:0] kind, logic en,
                                         int sx, int sy, int amt, int rx, int ry);
        t_req_beat r;
        r.req_type     = kind;
        r.spawn_enable = en;
        r.spawn_x      = COORD_W'(sx);
        r.spawn_y      = COORD_W'(sy);
        r.spawn_amount = AMOUNT_W'(amt);
        r.read_x       = COORD_W'(rx);
        r.read_y       = COORD_W'(ry);
        return r;
    endfunction

    task automatic send_req(t_req_beat r, int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // drop valid and hold until every result is back
    task automatic wait_settled();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (ripple.outstanding() != 0) @(posedge i_clk);
    endtask

    // acceptance sampling, scoreboard updates and the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                ripple.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                ripple.check_response(rsp_if.data);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // response side: random back-pressure, one long hold-off on request
    initial begin : rsp_side
        int gap;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req <= 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap(rcv_calm);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin : req_side
        t_req_beat          r;
        int                 pick;
        int                 adv_left;
        int                 clr_left;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;

        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, wrap of splash and sweep, ignored fields, clear, unused kind
        send_req(mk_req(REQ_READ,    1, 127, 127, 1023,   0,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_UNUSED,  1, 127, 127, 1023, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 1,   0,   0, 1023,  85,  42), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,  42,  85,    0,   0,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    1,  85,  42,  682, 127,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0,   0, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 0,  85,  42, 1023, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0,   1,   1), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 1, 127, 127,    3,   0,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 1, 127, 127, 1023,  42,  85), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0,   0, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0, 127,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_CLEAR,   1,  64,  64,  512, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0, 127, 127), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 1,  64,  64,    0,   0,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0,  64,  64), draw_gap(snd_calm));
        send_req(mk_req(REQ_ADVANCE, 1,  64,  64,  512,   0,   0), draw_gap(snd_calm));
        send_req(mk_req(REQ_READ,    0,   0,   0,    0,  64,  63), draw_gap(snd_calm));

        // sender pause: hold until every result is back
        wait_settled();

        adv_left = 15;
        clr_left = 3;
        last_x   = 7'd64;
        last_y   = 7'd64;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 40) begin
                // stall the response side and flood with reads to back the block up
                hold_off_req <= 1'b1;
                for (int k = 0; k < 12; k++) begin
                    r = t_req_beat'(REQ_BITS'({$urandom, $urandom}));
                    r.req_type = REQ_READ;
                    r.read_x   = last_x + COORD_W'($urandom_range(0, 8) - 4);
                    r.read_y   = last_y + COORD_W'($urandom_range(0, 8) - 4);
                    send_req(r, 0);
                end
            end
            if (n == 60)
                wait_settled();
            r = t_req_beat'(REQ_BITS'({$urandom, $urandom}));
            pick = $urandom_range(0, 99);
            if (pick < 14 && adv_left > 0) begin
                adv_left--;
                r.req_type     = REQ_ADVANCE;
                r.spawn_enable = ($urandom_range(0, 9) < 7);
                if (r.spawn_enable) begin
                    last_x = r.spawn_x;
                    last_y = r.spawn_y;
                end
            end else if (pick >= 14 && pick < 17 && clr_left > 0) begin
                clr_left--;
                r.req_type = REQ_CLEAR;
            end else if (pick >= 17 && pick < 20) begin
                r.req_type = REQ_UNUSED;
            end else begin
                r.req_type = REQ_READ;
                // mostly look where the ripples are
                if ($urandom_range(0, 9) < 6) begin
                    r.read_x = last_x + COORD_W'($urandom_range(0, 40) - 20);
                    r.read_y = last_y + COORD_W'($urandom_range(0, 40) - 20);
                end
            end
            send_req(r, draw_gap(snd_calm));
        end

        wait_settled();
        repeat (DRAIN) @(posedge i_clk);
        ripple.check_drained();
        if (ripple.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/wrhf_pkg.sv
hw/rtl/wrhf_chan_if.sv
hw/rtl/water_ripple_height_field.sv
hw/rtl/wrhf_checker.sv
tb/sv/tb.sv
